// ----- rtl/core/wjss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjss_pkg
// shared sizes, limits, codes and types of the joint solution selector
// ----------------------------------------------------------------------------
package wjss_pkg;

  localparam int JOINT_COUNT  = 6;
  localparam int ANGLE_BITS   = 16;
  localparam int WEIGHT_BITS  = 16;
  localparam int FRAC_DROP    = 9;
  localparam int DIFF_BITS    = ANGLE_BITS + 1;
  localparam int MAG_BITS     = ANGLE_BITS;
  localparam int PROD_BITS    = MAG_BITS + WEIGHT_BITS;
  localparam int TERM_BITS    = PROD_BITS - FRAC_DROP;
  localparam int SQ_BITS      = 2 * TERM_BITS;
  localparam int COST_BITS    = 51;

  localparam int CFG_COUNT    = 6;
  localparam int CFG_IDX_BITS = 3;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(4096);

  localparam int JIDX_BITS    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int CNT_BITS     = $clog2(JOINT_COUNT + 2);

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // joints past the limited ones have no limit
  localparam int LIMITED_JOINTS = 6;
  localparam int LIM_LO [6] = '{-4825, -3216, -3216, -5540, -3216, -9829};
  localparam int LIM_HI [6] = '{ 4825,  5361,  2823,  5540,  4825,  9829};

  localparam logic OP_REFERENCE = 1'b0;
  localparam logic OP_CANDIDATE = 1'b1;

  typedef logic [JOINT_COUNT-1:0][ANGLE_BITS-1:0]  angle_vec_t;
  typedef logic [JOINT_COUNT-1:0][WEIGHT_BITS-1:0] weight_vec_t;

  typedef struct packed {
    logic       op;
    logic       final_item;
    logic       in_lim;
    angle_vec_t angles;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic in_limit(input logic signed [ANGLE_BITS-1:0] a, input int j);
    int v;
    v = int'(a);
    if (j >= LIMITED_JOINTS) return 1'b1;
    return (v >= LIM_LO[j]) && (v <= LIM_HI[j]);
  endfunction

endpackage

// ----- rtl/core/wjss_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjss_front
// input beat acceptance and joint limit classification
// ----------------------------------------------------------------------------
module wjss_front import wjss_pkg::*; (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic signed [ANGLE_BITS-1:0] in_angle_1,
  input  logic signed [ANGLE_BITS-1:0] in_angle_2,
  input  logic signed [ANGLE_BITS-1:0] in_angle_3,
  input  logic signed [ANGLE_BITS-1:0] in_angle_4,
  input  logic signed [ANGLE_BITS-1:0] in_angle_5,
  input  logic signed [ANGLE_BITS-1:0] in_angle_6,
  input  logic                         in_final_item,
  input  fifo_stat_t                   q_stat,
  output logic                         push,
  output item_t                        push_item
);

  angle_vec_t angles;
  logic [JOINT_COUNT-1:0] lim_ok;

  always_comb begin
    angles    = '0;
    angles[0] = in_angle_1;
    angles[1] = in_angle_2;
    angles[2] = in_angle_3;
    angles[3] = in_angle_4;
    angles[4] = in_angle_5;
    angles[5] = in_angle_6;
    for (int j = 0; j < JOINT_COUNT; j++) begin
      lim_ok[j] = in_limit($signed(angles[j]), j);
    end
  end

  assign in_stall             = q_stat.full;
  assign push                 = in_valid && !q_stat.full;
  assign push_item.op         = in_operation;
  assign push_item.final_item = in_final_item;
  assign push_item.in_lim     = &lim_ok;
  assign push_item.angles     = angles;

endmodule

// ----- rtl/core/wjss_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjss_fifo
// short item queue between front and back
// ----------------------------------------------------------------------------
module wjss_fifo import wjss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  item_t      push_item,
  input  logic       pop,
  output item_t      head,
  output fifo_stat_t stat
);

  item_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/core/wjss_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjss_back
// weighted cost sequencer, best tracking and result register
// ----------------------------------------------------------------------------
module wjss_back import wjss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  item_t       head,
  input  fifo_stat_t  q_stat,
  output logic        pop,
  input  weight_vec_t weights,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output angle_vec_t  out_best
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_CMP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  item_t                  item_r, item_nxt;
  angle_vec_t             ref_r, ref_nxt;
  angle_vec_t             best_r, best_nxt;
  logic [COST_BITS-1:0]   best_cost_r, best_cost_nxt;
  logic                   have_best_r, have_best_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [PROD_BITS-1:0]   prod_r, prod_nxt;
  logic                   p1v_r, p1v_nxt;
  logic [SQ_BITS-1:0]     sq_r, sq_nxt;
  logic                   p2v_r, p2v_nxt;
  logic [COST_BITS-1:0]   acc_r, acc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  angle_vec_t             out_best_r, out_best_nxt;

  logic                   in_range;
  logic [JIDX_BITS-1:0]   jsel;
  logic signed [DIFF_BITS-1:0] diff;
  logic [DIFF_BITS-1:0]   mag_full;
  logic [TERM_BITS-1:0]   term;
  logic                   out_free;

  assign in_range = (cnt_r < CNT_BITS'(JOINT_COUNT));
  assign jsel     = in_range ? cnt_r[JIDX_BITS-1:0] : '0;
  assign diff     = $signed({item_r.angles[jsel][ANGLE_BITS-1], item_r.angles[jsel]})
                  - $signed({ref_r[jsel][ANGLE_BITS-1], ref_r[jsel]});
  assign mag_full = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
  assign term     = prod_r[PROD_BITS-1:FRAC_DROP];
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == S_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    ref_nxt       = ref_r;
    best_nxt      = best_r;
    best_cost_nxt = best_cost_r;
    have_best_nxt = have_best_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    out_found_nxt = out_found_r;
    out_best_nxt  = out_best_r;
    out_valid_nxt = out_valid_r && out_stall;

    // three stage joint pipe: weight product, truncate and square, sum
    prod_nxt = PROD_BITS'(mag_full[MAG_BITS-1:0] * weights[jsel]);
    p1v_nxt  = (state_r == S_RUN) && in_range;
    sq_nxt   = SQ_BITS'(term * term);
    p2v_nxt  = p1v_r;
    if (p2v_r) begin
      acc_nxt = acc_r + COST_BITS'(sq_r);
    end

    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          item_nxt = head;
          if (head.op == OP_REFERENCE) begin
            ref_nxt       = head.angles;
            best_nxt      = '0;
            best_cost_nxt = '1;
            have_best_nxt = 1'b0;
            state_nxt     = S_FIN;
          end else begin
            cnt_nxt   = '0;
            acc_nxt   = '0;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(JOINT_COUNT + 1)) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (acc_r < best_cost_r && item_r.in_lim) begin
          best_cost_nxt = acc_r;
          best_nxt      = item_r.angles;
          have_best_nxt = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!item_r.final_item) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = have_best_r;
          out_best_nxt  = best_r;
          best_nxt      = '0;
          best_cost_nxt = '1;
          have_best_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ref_r       <= '0;
      best_r      <= '0;
      best_cost_r <= '1;
      have_best_r <= 1'b0;
      p1v_r       <= 1'b0;
      p2v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_r       <= ref_nxt;
      best_r      <= best_nxt;
      best_cost_r <= best_cost_nxt;
      have_best_r <= have_best_nxt;
      p1v_r       <= p1v_nxt;
      p2v_r       <= p2v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    cnt_r       <= cnt_nxt;
    prod_r      <= prod_nxt;
    sq_r        <= sq_nxt;
    acc_r       <= acc_nxt;
    out_found_r <= out_found_nxt;
    out_best_r  <= out_best_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_best  = out_best_r;

endmodule

// ----- rtl/core/weighted_joint_solution_select_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_joint_solution_select_unit
// picks the in-limit candidate joint vector closest to a reference vector
// under a per-joint weighted squared distance
// ----------------------------------------------------------------------------
//
//  channel | handshake           | beat contents
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_stall | operation, angle_1..6, final_item
//  out     | out_valid/out_stall | found, best_1..6
//  cfg     | cfg_valid/cfg_ready | cfg_index (weight_1..6), cfg_data
//
//  the back end handles a reference beat in S_IDLE and S_FIN, a candidate in
//  S_IDLE, S_RUN, S_CMP and S_FIN: it runs one joint per cycle through a shared
//  product and square pipe of three stages
//  rst_n is synchronous: weights go to 1.0, reference and best are cleared
//  a two-beat queue decouples input acceptance from the cost sequencer, so
//  in_stall rises only when the queue is full
//  a result waits in the output register under out_stall; the back end
//  holds on the final beat until that register frees up
//  cfg_ready is always high; writes to indexes past weight_6 are dropped
// ----------------------------------------------------------------------------
module weighted_joint_solution_select_unit import wjss_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic signed [ANGLE_BITS-1:0] in_angle_1,
  input  logic signed [ANGLE_BITS-1:0] in_angle_2,
  input  logic signed [ANGLE_BITS-1:0] in_angle_3,
  input  logic signed [ANGLE_BITS-1:0] in_angle_4,
  input  logic signed [ANGLE_BITS-1:0] in_angle_5,
  input  logic signed [ANGLE_BITS-1:0] in_angle_6,
  input  logic                         in_final_item,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_found,
  output logic signed [ANGLE_BITS-1:0] out_best_1,
  output logic signed [ANGLE_BITS-1:0] out_best_2,
  output logic signed [ANGLE_BITS-1:0] out_best_3,
  output logic signed [ANGLE_BITS-1:0] out_best_4,
  output logic signed [ANGLE_BITS-1:0] out_best_5,
  output logic signed [ANGLE_BITS-1:0] out_best_6,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [WEIGHT_BITS-1:0]       cfg_data
);

  // per-joint weights, unsigned Q4.12
  weight_vec_t weights_r;

  fifo_stat_t  q_stat;
  logic        push, pop;
  item_t       push_item, head;
  angle_vec_t  out_best;

  assign cfg_ready = 1'b1;

  // indexes past the last weight are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        weights_r[j] <= WEIGHT_RESET;
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_BITS'(CFG_COUNT))) begin
      weights_r[cfg_index[JIDX_BITS-1:0]] <= cfg_data;
    end
  end

  // front: accept beats and tag the joint limit check
  wjss_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_angle_1    (in_angle_1),
    .in_angle_2    (in_angle_2),
    .in_angle_3    (in_angle_3),
    .in_angle_4    (in_angle_4),
    .in_angle_5    (in_angle_5),
    .in_angle_6    (in_angle_6),
    .in_final_item (in_final_item),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  // queue between the two halves
  wjss_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // back: cost, best tracking, result register
  wjss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .weights   (weights_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_found (out_found),
    .out_best  (out_best)
  );

  assign out_best_1 = out_best[0];
  assign out_best_2 = out_best[1];
  assign out_best_3 = out_best[2];
  assign out_best_4 = out_best[3];
  assign out_best_5 = out_best[4];
  assign out_best_6 = out_best[5];

endmodule

// ----- rtl/core/wjss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjss_checker
// port level checks of the joint solution selector
// ----------------------------------------------------------------------------
module wjss_checker import wjss_pkg::*; (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_found,
  input logic signed [ANGLE_BITS-1:0] out_best_1,
  input logic signed [ANGLE_BITS-1:0] out_best_2,
  input logic signed [ANGLE_BITS-1:0] out_best_3,
  input logic signed [ANGLE_BITS-1:0] out_best_4,
  input logic signed [ANGLE_BITS-1:0] out_best_5,
  input logic signed [ANGLE_BITS-1:0] out_best_6
);

  // result beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // empty run gives a zero vector
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_best_1 == '0) && (out_best_2 == '0) &&
      (out_best_3 == '0) && (out_best_4 == '0) && (out_best_5 == '0) && (out_best_6 == '0))
    else $error("best vector not zero without a find");

  // a found vector respects every joint limit
  a_found_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> in_limit(out_best_1, 0) && in_limit(out_best_2, 1) &&
      in_limit(out_best_3, 2) && in_limit(out_best_4, 3) && in_limit(out_best_5, 4) &&
      in_limit(out_best_6, 5))
    else $error("found vector outside joint limits");

endmodule

bind weighted_joint_solution_select_unit wjss_checker u_wjss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_found  (out_found),
  .out_best_1 (out_best_1),
  .out_best_2 (out_best_2),
  .out_best_3 (out_best_3),
  .out_best_4 (out_best_4),
  .out_best_5 (out_best_5),
  .out_best_6 (out_best_6)
);
